// ===== design/bilinear_texture_sampler_16bit_macros.svh =====
// Assertion macros shared by the bilinear texture sampler checker.
`ifndef BILINEAR_TEXTURE_SAMPLER_16BIT_MACROS_SVH
`define BILINEAR_TEXTURE_SAMPLER_16BIT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define BTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define BTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== design/bts_pkg.sv =====
// Shared types and constants of the bilinear texture sampler.
package bts_pkg;

  localparam int TEXEL_W  = 16;
  localparam int COORD_W  = 16;
  localparam int UV_W     = 17;
  localparam int FRAC_W   = 16;
  localparam int CFG_W    = 9;
  localparam int RESULT_W = 24;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 3;

  localparam logic [UV_W-1:0]     UV_ONE     = 17'h10000;
  localparam logic [RESULT_W-1:0] RESULT_MAX = 24'hFFFF00;

  // Register select taken from paddr[2]
  localparam logic REG_WIDTH_IDX  = 1'b0;
  localparam logic REG_HEIGHT_IDX = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_READ   = 2'd1,
    OP_SAMPLE = 2'd2
  } op_t;

endpackage

// ===== design/bts_ram.sv =====
// Generic single-clock RAM, one write port, one registered read port.
module bts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/bilinear_texture_sampler_16bit.sv =====
// Bilinear texture sampler top level: 16-bit texel store, clamp-to-edge sampling.
//
// Usage
//  - Request channel in_*: operation (write texel, read clamped texel, bilinear
//    sample), texel coordinates, texel data and Q1.16 u/v. A request is taken
//    on a rising edge with in_valid high and in_stall low.
//  - Result channel out_*: one result per request, in request order; writes,
//    unused opcodes and an empty image give zero. Texel units, 8 fraction bits.
//  - APB port sets image_width (0x0) and image_height (0x4); write it only
//    while no request is in flight. pready is tied high.
// Timing
//  - out_valid rises once the request has passed, in order: the scaling multiply,
//    registered at the accepting edge, then bank read, horizontal lerp, vertical lerp.
//  - One request per cycle sustained while out_stall is low. The store is split into four banks by
//    column and row parity, so the 2x2 footprint is read in a single access.
//  - Writes and reads hit the banks in request order, so read-after-write is exact.
// Reset and backpressure
//  - rst_n clears the size registers and all stage valids; texel contents stay
//    undefined until written, there is no clearing pass.
//  - out_stall freezes the output register; earlier stages keep filling their
//    empty slots, and in_stall rises only once every stage holds a request.
module bilinear_texture_sampler_16bit
  import bts_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  // request channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_operation,
  input  logic [COORD_W-1:0]  in_coord_x,
  input  logic [COORD_W-1:0]  in_coord_y,
  input  logic [TEXEL_W-1:0]  in_texel_in,
  input  logic [UV_W-1:0]     in_sample_u,
  input  logic [UV_W-1:0]     in_sample_v,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [RESULT_W-1:0] out_result_value,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready
);

  // index widths, effective-size widths, bank geometry
  localparam int XI     = $clog2(MAX_WIDTH);
  localparam int YI     = $clog2(MAX_HEIGHT);
  localparam int XW1    = $clog2(MAX_WIDTH + 1);
  localparam int YW1    = $clog2(MAX_HEIGHT + 1);
  localparam int HW     = (MAX_WIDTH + 1) / 2;
  localparam int HH     = (MAX_HEIGHT + 1) / 2;
  localparam int BDEPTH = HW * HH;
  localparam int BA     = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] cfg_width_r;
  logic [CFG_W-1:0] cfg_height_r;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= '0;
      cfg_height_r <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_HEIGHT_IDX) begin
        cfg_height_r <= pwdata[CFG_W-1:0];
      end else begin
        cfg_width_r <= pwdata[CFG_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_HEIGHT_IDX) ? APB_DW'(cfg_height_r)
                                               : APB_DW'(cfg_width_r);

  // effective size, saturated to the store dimensions
  logic [XW1-1:0] w_eff, w_m1_full;
  logic [YW1-1:0] h_eff, h_m1_full;
  logic [XI-1:0]  w_m1;
  logic [YI-1:0]  h_m1;
  logic           img_empty;

  assign w_eff = (32'(cfg_width_r) > MAX_WIDTH) ? XW1'(MAX_WIDTH) : XW1'(cfg_width_r);
  assign h_eff = (32'(cfg_height_r) > MAX_HEIGHT) ? YW1'(MAX_HEIGHT) : YW1'(cfg_height_r);
  assign w_m1_full = w_eff - XW1'(1);
  assign h_m1_full = h_eff - YW1'(1);
  assign w_m1      = w_m1_full[XI-1:0];
  assign h_m1      = h_m1_full[YI-1:0];
  assign img_empty = (w_eff == '0) || (h_eff == '0);

  // ---------------------------------------------------------------------------
  // stage enables: each stage moves when it is empty or its successor moves
  // ---------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic en1, en2, en3, en_out;

  assign en_out   = !out_valid_r || !out_stall;
  assign en3      = !v3_r || en_out;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;

  // ---------------------------------------------------------------------------
  // stage 0: decode, clamp, scale u/v to fixed-point texel positions
  // ---------------------------------------------------------------------------
  logic              wr_nxt, rd_nxt, zero_nxt;
  logic [XI+15:0]    px_nxt;
  logic [YI+15:0]    py_nxt;
  logic [XI-1:0]     xc;
  logic [YI-1:0]     yc;
  logic [UV_W-1:0]   u_sat, v_sat;
  logic [UV_W+XI-1:0] u_prod;
  logic [UV_W+YI-1:0] v_prod;
  logic              x_in, y_in;

  assign x_in   = 32'(in_coord_x) < 32'(w_eff);
  assign y_in   = 32'(in_coord_y) < 32'(h_eff);
  assign xc     = x_in ? in_coord_x[XI-1:0] : w_m1;
  assign yc     = y_in ? in_coord_y[YI-1:0] : h_m1;
  assign u_sat  = (in_sample_u > UV_ONE) ? UV_ONE : in_sample_u;
  assign v_sat  = (in_sample_v > UV_ONE) ? UV_ONE : in_sample_v;
  assign u_prod = (UV_W+XI)'(u_sat) * (UV_W+XI)'(w_m1);
  assign v_prod = (UV_W+YI)'(v_sat) * (UV_W+YI)'(h_m1);

  always_comb begin
    wr_nxt   = 1'b0;
    rd_nxt   = 1'b0;
    zero_nxt = 1'b1;
    px_nxt   = {xc, {FRAC_W{1'b0}}};
    py_nxt   = {yc, {FRAC_W{1'b0}}};
    unique case (in_operation)
      OP_WRITE: begin
        wr_nxt = x_in && y_in;
      end
      OP_READ: begin
        rd_nxt   = 1'b1;
        zero_nxt = img_empty;
      end
      OP_SAMPLE: begin
        zero_nxt = img_empty;
        px_nxt   = u_prod[XI+15:0];
        py_nxt   = v_prod[YI+15:0];
      end
      default: begin
        zero_nxt = 1'b1;
      end
    endcase
  end

  logic              wr1_r, rd1_r, zero1_r;
  logic [XI+15:0]    px1_r;
  logic [YI+15:0]    py1_r;
  logic [TEXEL_W-1:0] texel1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      wr1_r    <= wr_nxt;
      rd1_r    <= rd_nxt;
      zero1_r  <= zero_nxt;
      px1_r    <= px_nxt;
      py1_r    <= py_nxt;
      texel1_r <= in_texel_in;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: neighbor indices, bank addresses, bank access
  // ---------------------------------------------------------------------------
  logic [XI-1:0]     x0, x1;
  logic [YI-1:0]     y0, y1;
  logic [FRAC_W-1:0] dx, dy;
  logic              mem_rd, mem_wr;

  assign x0 = px1_r[FRAC_W +: XI];
  assign y0 = py1_r[FRAC_W +: YI];
  assign dx = px1_r[FRAC_W-1:0];
  assign dy = py1_r[FRAC_W-1:0];
  // a plain read uses one texel; keep the neighbor on it so no weight-zero fetch
  assign x1 = (!rd1_r && (x0 < w_m1)) ? x0 + XI'(1) : x0;
  assign y1 = (!rd1_r && (y0 < h_m1)) ? y0 + YI'(1) : y0;

  assign mem_wr = en2 && v1_r && wr1_r;
  assign mem_rd = en2 && v1_r && !zero1_r;

  logic [TEXEL_W-1:0] bank_rd [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam bit PC = (b % 2) == 1;
    localparam bit PR = (b / 2) == 1;
    logic [XI-1:0] col;
    logic [YI-1:0] row;
    logic [BA-1:0] addr;
    logic          we;

    assign col  = (x0[0] == PC) ? x0 : x1;
    assign row  = (y0[0] == PR) ? y0 : y1;
    assign addr = BA'(32'(row >> 1) * HW + 32'(col >> 1));
    assign we   = mem_wr && (x0[0] == PC) && (y0[0] == PR);

    bts_ram #(
      .WIDTH(TEXEL_W),
      .DEPTH(BDEPTH)
    ) u_ram (
      .clk  (clk),
      .we   (we),
      .waddr(addr),
      .wdata(texel1_r),
      .re   (mem_rd),
      .raddr(addr),
      .rdata(bank_rd[b])
    );
  end

  logic              zero2_r;
  logic [FRAC_W-1:0] dx2_r, dy2_r;
  logic [1:0]        xp2_r, yp2_r;  // parity of {x1, x0} and {y1, y0}

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1_r) begin
      zero2_r <= zero1_r;
      dx2_r   <= dx;
      dy2_r   <= dy;
      xp2_r   <= {x1[0], x0[0]};
      yp2_r   <= {y1[0], y0[0]};
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: horizontal interpolation, top = t00*2^16 + (t10 - t00)*dx
  // ---------------------------------------------------------------------------
  logic [TEXEL_W-1:0]  t00, t10, t01, t11;
  logic signed [16:0]  diff_t, diff_b, dx_s;
  logic signed [33:0]  prod_t, prod_b, sum_t, sum_b;
  logic [31:0]         top_nxt, bot_nxt;

  assign t00 = bank_rd[{yp2_r[0], xp2_r[0]}];
  assign t10 = bank_rd[{yp2_r[0], xp2_r[1]}];
  assign t01 = bank_rd[{yp2_r[1], xp2_r[0]}];
  assign t11 = bank_rd[{yp2_r[1], xp2_r[1]}];

  assign dx_s    = signed'({1'b0, dx2_r});
  assign diff_t  = signed'({1'b0, t10}) - signed'({1'b0, t00});
  assign diff_b  = signed'({1'b0, t11}) - signed'({1'b0, t01});
  assign prod_t  = 34'(diff_t) * 34'(dx_s);
  assign prod_b  = 34'(diff_b) * 34'(dx_s);
  assign sum_t   = signed'({2'b00, t00, {FRAC_W{1'b0}}}) + prod_t;
  assign sum_b   = signed'({2'b00, t01, {FRAC_W{1'b0}}}) + prod_b;
  assign top_nxt = sum_t[31:0];
  assign bot_nxt = sum_b[31:0];

  logic              zero3_r;
  logic [31:0]       top3_r, bot3_r;
  logic [FRAC_W-1:0] dy3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2_r) begin
      zero3_r <= zero2_r;
      top3_r  <= top_nxt;
      bot3_r  <= bot_nxt;
      dy3_r   <= dy2_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: vertical interpolation and truncation to 8 fraction bits
  // ---------------------------------------------------------------------------
  logic signed [32:0] diff_v;
  logic signed [49:0] prod_v, sum_v;
  logic [RESULT_W-1:0] result_nxt;

  assign diff_v     = signed'({1'b0, bot3_r}) - signed'({1'b0, top3_r});
  assign prod_v     = 50'(diff_v) * 50'(signed'({1'b0, dy3_r}));
  assign sum_v      = signed'({2'b00, top3_r, {FRAC_W{1'b0}}}) + prod_v;
  assign result_nxt = zero3_r ? '0 : sum_v[47:24];

  logic [RESULT_W-1:0] out_result_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_out) begin
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out && v3_r) begin
      out_result_value_r <= result_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_result_value_r;

endmodule

// ===== design/bts_checker.sv =====
// Port-level checker for the bilinear texture sampler, bound to the top level.
`include "bilinear_texture_sampler_16bit_macros.svh"

module bts_checker
  import bts_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [RESULT_W-1:0] out_result_value
);

  `BTS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
  `BTS_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_result_value), "stalled result changed")
  // pipeline collapses bubbles: an empty output slot means room for a request
  `BTS_ASSERT_NOW(a_no_idle_stall, !out_valid, !in_stall, "request stalled with empty output")
  // largest value is a full-scale texel with no fraction
  `BTS_ASSERT_NOW(a_result_range, out_valid, out_result_value <= RESULT_MAX, "result out of range")

endmodule

bind bilinear_texture_sampler_16bit bts_checker u_bts_checker (.*);

// ===== tb/sampler_check_pkg.sv =====
// Scoreboard for the bilinear texture sampler: texel mirror, result prediction and checks.
package sampler_check_pkg;
  import bts_pkg::*;

  localparam int MIRROR_W = 256;
  localparam int MIRROR_H = 256;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam longint unsigned ONE_Q16 = 64'd65536;
  localparam int MAX_REPORTS = 10;

  class texel_scoreboard;
    bit [TEXEL_W-1:0] texel_mirror [MIRROR_W*MIRROR_H];
    int unsigned img_w = 0;
    int unsigned img_h = 0;
    logic [RESULT_W-1:0] expected_values [$];
    int unsigned failures = 0;
    int unsigned reported = 0;

    function int unsigned eff_width();
      return (img_w > MIRROR_W) ? MIRROR_W : img_w;
    endfunction

    function int unsigned eff_height();
      return (img_h > MIRROR_H) ? MIRROR_H : img_h;
    endfunction

    function void set_size(logic idx, logic [CFG_W-1:0] value);
      if (idx == REG_WIDTH_IDX) begin
        img_w = 32'(value);
      end else begin
        img_h = 32'(value);
      end
    endfunction

    function int pending();
      return expected_values.size();
    endfunction

    function logic [TEXEL_W-1:0] texel_at(int unsigned col, int unsigned row);
      return texel_mirror[row*MIRROR_W + col];
    endfunction

    function void flag(string msg);
      failures++;
      if (reported < MAX_REPORTS) begin
        reported++;
        $display("mismatch: %s", msg);
      end
    endfunction

    // Applies one request to the mirror and returns the value it should produce.
    function logic [RESULT_W-1:0] predict_result(logic [1:0] op,
                                                 logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                                 logic [TEXEL_W-1:0] t,
                                                 logic [UV_W-1:0] u, logic [UV_W-1:0] v);
      longint unsigned su, sv, px, py, dx, dy, top, bot, blend;
      int unsigned w, h, x0, y0, x1, y1;
      logic [RESULT_W-1:0] res;
      res = '0;
      w = eff_width();
      h = eff_height();
      case (op)
        OP_WRITE: begin
          if (x < w && y < h) texel_mirror[y*MIRROR_W + x] = t;
        end
        OP_READ: begin
          if (w != 0 && h != 0) begin
            x0 = (x < w) ? x : w - 1;
            y0 = (y < h) ? y : h - 1;
            res = {texel_at(x0, y0), 8'h00};
          end
        end
        OP_SAMPLE: begin
          if (w != 0 && h != 0) begin
            su = (u > UV_ONE) ? UV_ONE : u;
            sv = (v > UV_ONE) ? UV_ONE : v;
            px = su * (w - 1);
            py = sv * (h - 1);
            x0 = 32'(px >> FRAC_W);
            y0 = 32'(py >> FRAC_W);
            dx = px & (ONE_Q16 - 1);
            dy = py & (ONE_Q16 - 1);
            if (x0 > w - 1) x0 = w - 1;
            if (y0 > h - 1) y0 = h - 1;
            x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
            y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
            top = texel_at(x0, y0) * (ONE_Q16 - dx) + texel_at(x1, y0) * dx;
            bot = texel_at(x0, y1) * (ONE_Q16 - dx) + texel_at(x1, y1) * dx;
            blend = (top * (ONE_Q16 - dy) + bot * dy) >> 24;
            res = blend[RESULT_W-1:0];
          end
        end
        default: ;
      endcase
      return res;
    endfunction

    function void note_request(logic [1:0] op,
                               logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                               logic [TEXEL_W-1:0] t,
                               logic [UV_W-1:0] u, logic [UV_W-1:0] v);
      expected_values.push_back(predict_result(op, x, y, t, u, v));
    endfunction

    function void check_result(logic [RESULT_W-1:0] got);
      logic [RESULT_W-1:0] want;
      if (expected_values.size() == 0) begin
        flag($sformatf("result %06h arrived with no request pending", got));
      end else begin
        want = expected_values.pop_front();
        if (got !== want)
          flag($sformatf("result_value expected %06h got %06h", want, got));
      end
    endfunction

    function void leftover_check();
      if (expected_values.size() != 0)
        flag($sformatf("%0d results never arrived", expected_values.size()));
    endfunction
  endclass

endpackage

// ===== tb/tb.sv =====
// Testbench top for the bilinear texture sampler: stimulus, idling, pressure and checks.
module tb;
  import bts_pkg::*;
  import sampler_check_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int HOLD_CYCLES  = 80;   // long receiver hold-off, fills every stage
  localparam int TAIL_CYCLES  = 12;   // pipeline is four deep, leave some margin
  localparam logic [APB_AW-1:0] ADDR_IMAGE_WIDTH  = {REG_WIDTH_IDX, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_IMAGE_HEIGHT = {REG_HEIGHT_IDX, 2'b00};

  // Idling profiles, one per phase
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          in_operation = '0;
  logic [COORD_W-1:0]  in_coord_x = '0;
  logic [COORD_W-1:0]  in_coord_y = '0;
  logic [TEXEL_W-1:0]  in_texel_in = '0;
  logic [UV_W-1:0]     in_sample_u = '0;
  logic [UV_W-1:0]     in_sample_v = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [RESULT_W-1:0] out_result_value;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_go = 1'b0;
  logic        long_hold = 1'b0;
  int unsigned cycle_count = 0;

  texel_scoreboard sb = new();

  bilinear_texture_sampler_16bit #(
    .MAX_WIDTH (MIRROR_W),
    .MAX_HEIGHT(MIRROR_H)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .in_texel_in     (in_texel_in),
    .in_sample_u     (in_sample_u),
    .in_sample_v     (in_sample_v),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_value(out_result_value),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #6 clk = ~clk;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side. Sampling right after the edge sees the pre-edge values, so a
  // result counts when out_valid was high and our stall was low at that edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) sb.check_result(out_result_value);
      out_stall <= long_hold || ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Long hold-off: once armed, the receiver stalls for a fixed stretch while
  // the sender keeps pushing, so the pipe fills and in_stall has to rise.
  initial begin
    wait (hold_go);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  task automatic set_idling(int mode);
    case (mode)
      IDLE_SEND: begin send_idle_pct = 73; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 73; end
      IDLE_BOTH: begin send_idle_pct = 34; recv_stall_pct = 34; end
      default:   begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endtask

  // One request: optional idle gap, then hold valid and payload until taken.
  // valid is only ever assigned once per edge, so back-to-back requests keep it high.
  task automatic send_request(logic [1:0] op, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                              logic [TEXEL_W-1:0] t, logic [UV_W-1:0] u, logic [UV_W-1:0] v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_coord_x   <= x;
    in_coord_y   <= y;
    in_texel_in  <= t;
    in_sample_u  <= u;
    in_sample_v  <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(op, x, y, t, u, v);
  endtask

  // Drop valid and let every outstanding result come back.
  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle; lands at the edge with pready high.
  // Upper data bits are random, only the low nine belong to the register.
  task automatic write_size(logic idx, logic [CFG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= (idx == REG_WIDTH_IDX) ? ADDR_IMAGE_WIDTH : ADDR_IMAGE_HEIGHT;
    pwdata  <= {23'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_size(idx, value);
  endtask

  // Random mix over a fully written image: reads and samples only ever touch
  // texels inside the image, so nothing unwritten is read back.
  task automatic random_request();
    int unsigned w, h, pick;
    logic [1:0] op;
    logic [COORD_W-1:0] x, y;
    logic [TEXEL_W-1:0] t;
    logic [UV_W-1:0] u, v;
    w = sb.eff_width();
    h = sb.eff_height();
    pick = $urandom_range(0, 99);
    x = COORD_W'($urandom);
    y = COORD_W'($urandom);
    t = TEXEL_W'($urandom);
    u = UV_W'($urandom);
    v = UV_W'($urandom);
    if (pick < 25) begin
      op = OP_WRITE;
      if (w != 0 && h != 0) begin
        x = COORD_W'($urandom_range(0, w - 1));
        y = COORD_W'($urandom_range(0, h - 1));
      end
    end else if (pick < 33) begin
      op = OP_WRITE;                       // anywhere, mostly off the image
    end else if (pick < 53) begin
      op = OP_READ;
      if ($urandom_range(0, 1)) begin      // near the edge; else full-range clamp
        x = COORD_W'($urandom_range(0, w + 2));
        y = COORD_W'($urandom_range(0, h + 2));
      end
    end else if (pick < 95) begin
      op = OP_SAMPLE;
      case ($urandom_range(0, 3))
        0: begin
          u = UV_W'($urandom_range(0, UV_ONE));
          v = UV_W'($urandom_range(0, UV_ONE));
        end
        1: ;                               // full 17-bit range, saturation above one
        2: begin
          u = $urandom_range(0, 1) ? UV_ONE : '0;
          v = $urandom_range(0, 1) ? UV_ONE : '0;
        end
        default: begin
          u = UV_W'($urandom_range(0, UV_ONE));
          v = $urandom_range(0, 1) ? UV_ONE : UV_W'($urandom_range(0, 255));
        end
      endcase
    end else begin
      op = OP_UNUSED;
    end
    send_request(op, x, y, t, u, v);
  endtask

  // A phase: resize while idle, write every texel of the image, then random traffic.
  task automatic run_phase(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h, int mode,
                           int unsigned n_random, bit with_hold);
    int unsigned row, col;
    wait_results_done();
    write_size(REG_WIDTH_IDX, w);
    write_size(REG_HEIGHT_IDX, h);
    set_idling(mode);
    if (with_hold) hold_go <= 1'b1;
    for (row = 0; row < sb.eff_height(); row++) begin
      for (col = 0; col < sb.eff_width(); col++) begin
        send_request(OP_WRITE, COORD_W'(col), COORD_W'(row), TEXEL_W'($urandom),
                     UV_W'($urandom), UV_W'($urandom));
      end
    end
    repeat (n_random) random_request();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty image after reset: write ignored, read and sample give zero,
    // unused opcode gives zero.
    send_request(OP_WRITE, '0, '0, 16'hFFFF, '0, '0);
    send_request(OP_READ, '0, '0, '0, '0, '0);
    send_request(OP_SAMPLE, '0, '0, '0, UV_ONE, UV_ONE);
    send_request(OP_UNUSED, '1, '1, '1, '1, '1);

    // 2x2 image with extreme texel values
    wait_results_done();
    write_size(REG_WIDTH_IDX, 9'd2);
    write_size(REG_HEIGHT_IDX, 9'd2);
    send_request(OP_WRITE, 16'd0, 16'd0, 16'h0000, '0, '0);
    send_request(OP_WRITE, 16'd1, 16'd0, 16'hFFFF, '0, '0);
    send_request(OP_WRITE, 16'd0, 16'd1, 16'h8001, '0, '0);
    send_request(OP_WRITE, 16'd1, 16'd1, 16'h7FFE, '0, '0);
    // a read clamped at the far corner, then a read inside the image
    send_request(OP_READ, 16'hFFFF, 16'hFFFF, '0, '0, '0);
    send_request(OP_READ, 16'd1, 16'd0, '0, '0, '0);
    // samples: origin, exactly one, saturated above one, center, odd fractions
    send_request(OP_SAMPLE, '0, '0, '0, '0, '0);
    send_request(OP_SAMPLE, '0, '0, '0, UV_ONE, UV_ONE);
    send_request(OP_SAMPLE, '0, '0, '0, '1, '1);
    send_request(OP_SAMPLE, '0, '0, '0, 17'h08000, 17'h08000);
    send_request(OP_SAMPLE, '0, '0, '0, 17'h0FFFF, 17'h00001);
    // writes off the image are dropped; the clamped read shows the old value
    send_request(OP_WRITE, 16'd2, 16'd0, 16'h1111, '0, '0);
    send_request(OP_WRITE, 16'd0, 16'hFFFF, 16'h2222, '0, '0);
    send_request(OP_READ, 16'hFFFF, 16'd0, '0, '0, '0);
    // read right behind a write to the same texel
    send_request(OP_WRITE, 16'd1, 16'd1, 16'hABCD, '0, '0);
    send_request(OP_READ, 16'd1, 16'd1, '0, '0, '0);
    send_request(OP_UNUSED, '1, '1, '1, '1, '1);

    // Random phases; oversized registers saturate, single-texel and empty
    // images included. The long hold-off rides on a phase with no idling.
    run_phase(9'd5,   9'd3,   IDLE_NONE, 70, 1'b0);
    run_phase(9'd12,  9'd10,  IDLE_SEND, 70, 1'b0);
    run_phase(9'd511, 9'd1,   IDLE_NONE, 70, 1'b1);
    run_phase(9'd1,   9'd384, IDLE_RECV, 70, 1'b0);
    run_phase(9'd1,   9'd1,   IDLE_BOTH, 70, 1'b0);
    run_phase(9'd0,   9'd9,   IDLE_SEND, 70, 1'b0);
    run_phase(9'd6,   9'd0,   IDLE_RECV, 70, 1'b0);
    run_phase(9'd2,   9'd2,   IDLE_BOTH, 70, 1'b0);
    run_phase(9'd37,  9'd3,   IDLE_BOTH, 70, 1'b0);
    run_phase(9'd256, 9'd1,   IDLE_RECV, 70, 1'b0);

    wait_results_done();
    repeat (TAIL_CYCLES) @(posedge clk);
    sb.leftover_check();
    if (sb.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
